// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker; sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every sampled edge out of reset.
`define RDTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rdtc assertion failed");

// Signal holds its value in the cycle after cond.
`define RDTC_ASSERT_HOLD(lbl, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("rdtc hold assertion failed");

`endif

// ===== hdl/rdtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdtc_pkg
// Shared widths, register codes, level codes and status types.
// ----------------------------------------------------------------------------
package rdtc_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int DT_W     = 16;
    localparam int STAMP_W  = 32;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int LEVEL_W  = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SHORT_WINDOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LONG_WINDOW    = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIGH_FLOOR     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HIGH_DROP      = 3'd3;
    localparam logic [IDX_W-1:0] REG_ELEVATED_FLOOR = 3'd4;
    localparam logic [IDX_W-1:0] REG_ELEVATED_DROP  = 3'd5;
    localparam logic [IDX_W-1:0] REG_WATCH_DROP     = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SHORT_WINDOW   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_LONG_WINDOW    = 16'd10000;
    localparam logic [CFG_W-1:0] RST_HIGH_FLOOR     = 16'd0;
    localparam logic [CFG_W-1:0] RST_HIGH_DROP      = 16'hFFFF;
    localparam logic [CFG_W-1:0] RST_ELEVATED_FLOOR = 16'd0;
    localparam logic [CFG_W-1:0] RST_ELEVATED_DROP  = 16'hFFFF;
    localparam logic [CFG_W-1:0] RST_WATCH_DROP     = 16'hFFFF;

    // trend levels
    localparam logic [LEVEL_W-1:0] LEVEL_NONE     = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WATCH    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_ELEVATED = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH     = 2'd3;

    // walker status toward the top level
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [SAMPLE_W-1:0] ref_short;
        logic [SAMPLE_W-1:0] ref_long;
    } walk_status_t;

endpackage

// ===== hdl/rdtc_ifs.sv =====
// ----------------------------------------------------------------------------
// rdtc_ifs
// Valid/ready channel interfaces: sample input, level output, config write.
// ----------------------------------------------------------------------------
interface rdtc_sample_if;
    import rdtc_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] readiness_sample;
    logic signed [DT_W-1:0] elapsed_ms;

    modport source (output valid, output readiness_sample, output elapsed_ms, input ready);
    modport sink   (input valid, input readiness_sample, input elapsed_ms, output ready);
endinterface

interface rdtc_level_if;
    import rdtc_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] trend_level;

    modport source (output valid, output trend_level, input ready);
    modport sink   (input valid, input trend_level, output ready);
endinterface

interface rdtc_cfg_if;
    import rdtc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] reg_index;
    logic [CFG_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hdl/rdtc_ring.sv =====
// ----------------------------------------------------------------------------
// rdtc_ring
// Sample/stamp history memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rdtc_ring #(
    parameter int DEPTH = rdtc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [rdtc_pkg::SAMPLE_W-1:0] wsample,
    input  logic [rdtc_pkg::STAMP_W-1:0]  wstamp,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [rdtc_pkg::SAMPLE_W-1:0] rsample,
    output logic [rdtc_pkg::STAMP_W-1:0]  rstamp
);
    import rdtc_pkg::*;

    logic [SAMPLE_W-1:0] sample_mem [DEPTH];
    logic [STAMP_W-1:0]  stamp_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sample_mem[waddr] <= wsample;
            stamp_mem[waddr]  <= wstamp;
        end
        if (re)
        begin
            rsample <= sample_mem[raddr];
            rstamp  <= stamp_mem[raddr];
        end
    end

endmodule

// ===== hdl/rdtc_walk.sv =====
// ----------------------------------------------------------------------------
// rdtc_walk
// Newest-to-oldest history walk; one shared age/window compare per entry.
// ----------------------------------------------------------------------------
module rdtc_walk #(
    parameter int DEPTH = rdtc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(DEPTH)-1:0]      start_slot,
    input  logic [$clog2(DEPTH+1)-1:0]    start_count,
    input  logic [rdtc_pkg::STAMP_W-1:0]  clock_now,
    input  logic [rdtc_pkg::CFG_W-1:0]    short_win,
    input  logic [rdtc_pkg::CFG_W-1:0]    long_win,
    input  logic                          take,
    output logic                          rd_en,
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    input  logic [rdtc_pkg::SAMPLE_W-1:0] rd_sample,
    input  logic [rdtc_pkg::STAMP_W-1:0]  rd_stamp,
    output rdtc_pkg::walk_status_t        status
);
    import rdtc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {W_IDLE, W_WALK, W_DONE} wstate_t;

    wstate_t             state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       iss_left_reg, iss_left_next;
    logic [CW-1:0]       ev_left_reg, ev_left_next;
    logic                pend_reg, pend_next;
    logic                sfound_reg, sfound_next;
    logic                lfound_reg, lfound_next;
    logic [SAMPLE_W-1:0] rshort_reg, rshort_next;
    logic [SAMPLE_W-1:0] rlong_reg, rlong_next;

    logic [STAMP_W-1:0]  age;
    logic                hit_s, hit_l, last;

    // shared compare unit: age of the returned entry against both windows
    assign age   = clock_now - rd_stamp;
    assign hit_s = age >= {{(STAMP_W-CFG_W){1'b0}}, short_win};
    assign hit_l = age >= {{(STAMP_W-CFG_W){1'b0}}, long_win};
    assign last  = ev_left_reg == CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        iss_left_next = iss_left_reg;
        ev_left_next  = ev_left_reg;
        pend_next     = pend_reg;
        sfound_next   = sfound_reg;
        lfound_next   = lfound_reg;
        rshort_next   = rshort_reg;
        rlong_next    = rlong_reg;
        rd_en         = 1'b0;
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    state_next    = W_WALK;
                    addr_next     = start_slot;
                    iss_left_next = start_count;
                    ev_left_next  = start_count;
                    pend_next     = 1'b0;
                    sfound_next   = 1'b0;
                    lfound_next   = 1'b0;
                end
            end
            W_WALK:
            begin
                pend_next = iss_left_reg != '0;
                if (iss_left_reg != '0)
                begin
                    rd_en         = 1'b1;
                    iss_left_next = iss_left_reg - CW'(1);
                    addr_next     = (addr_reg == '0) ? AW'(DEPTH - 1) : addr_reg - AW'(1);
                end
                if (pend_reg)
                begin
                    ev_left_next = ev_left_reg - CW'(1);
                    // oldest entry is the fallback reference
                    if (!sfound_reg && (hit_s || last))
                    begin
                        rshort_next = rd_sample;
                        sfound_next = 1'b1;
                    end
                    if (!lfound_reg && (hit_l || last))
                    begin
                        rlong_next  = rd_sample;
                        lfound_next = 1'b1;
                    end
                    if ((sfound_reg || hit_s || last) && (lfound_reg || hit_l || last))
                    begin
                        state_next = W_DONE;
                    end
                end
            end
            W_DONE:
            begin
                if (take)
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= W_IDLE;
            pend_reg     <= 1'b0;
            sfound_reg   <= 1'b0;
            lfound_reg   <= 1'b0;
            iss_left_reg <= '0;
            ev_left_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            sfound_reg   <= sfound_next;
            lfound_reg   <= lfound_next;
            iss_left_reg <= iss_left_next;
            ev_left_reg  <= ev_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        rshort_reg <= rshort_next;
        rlong_reg  <= rlong_next;
    end

    assign rd_addr          = addr_reg;
    assign status.busy      = state_reg != W_IDLE;
    assign status.done      = state_reg == W_DONE;
    assign status.ref_short = rshort_reg;
    assign status.ref_long  = rlong_reg;

endmodule

// ===== hdl/readiness_drop_trend_classifier_core.sv =====
// ----------------------------------------------------------------------------
// readiness_drop_trend_classifier_core
// Readiness history with short/long window drop references and 4-level trend.
// ----------------------------------------------------------------------------
//
//  channel     dir   payload                              transfer when
//  ---------   ---   ----------------------------------   ------------------
//  sample_ch   in    readiness_sample[16], elapsed_ms[16s] valid && ready
//  level_ch    out   trend_level[2]                       valid && ready
//  cfg_ch      in    reg_index[3], wr_data[16]            valid && ready
//
//  The walk reads one history entry per cycle through the single read port of
//  the ring memory and stops early once both references have turned up.
//  Reset: control state cleared, config registers set to reset values; history
//  memory is not cleared (only written entries are ever read), so no clearing pass.
//  sample_ch.ready is low from the transfer until the result is moved into the
//  output register; a stalled level_ch holds its result while a new sample is
//  taken in, and the walk then waits in its done state for the register.
//  cfg_ch is always ready; writes are expected only while idle.
//
module readiness_drop_trend_classifier_core #(
    parameter int HISTORY_DEPTH = rdtc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    rdtc_sample_if.sink        sample_ch,
    rdtc_level_if.source       level_ch,
    rdtc_cfg_if.sink           cfg_ch
);
    import rdtc_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    // configuration registers
    logic [CFG_W-1:0] short_window_reg, long_window_reg;
    logic [CFG_W-1:0] high_floor_reg, high_drop_reg;
    logic [CFG_W-1:0] elevated_floor_reg, elevated_drop_reg;
    logic [CFG_W-1:0] watch_drop_reg;

    // history bookkeeping
    logic [STAMP_W-1:0]  clock_reg, clock_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [CW-1:0]       held_reg, held_next;
    logic [SAMPLE_W-1:0] r_now_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic               in_xfer, cfg_xfer, take, dt_pos;
    walk_status_t       walk_st;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [SAMPLE_W-1:0] rd_sample;
    logic [STAMP_W-1:0] rd_stamp;

    logic signed [SAMPLE_W:0] fall_short, fall_long;

    assign sample_ch.ready = !walk_st.busy;
    assign in_xfer         = sample_ch.valid && sample_ch.ready;
    assign cfg_ch.ready    = 1'b1;
    assign cfg_xfer        = cfg_ch.valid && cfg_ch.ready;

    // only a strictly positive elapsed time moves the clock (wraps mod 2^32)
    assign dt_pos     = !sample_ch.elapsed_ms[DT_W-1] && (sample_ch.elapsed_ms != '0);
    assign clock_next = in_xfer && dt_pos
                      ? clock_reg + {{(STAMP_W-DT_W){1'b0}}, sample_ch.elapsed_ms}
                      : clock_reg;
    assign wp_next    = !in_xfer ? wp_reg
                      : (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign held_next  = (in_xfer && held_reg != CW'(HISTORY_DEPTH)) ? held_reg + CW'(1)
                      : held_reg;

    // the new sample is written at the transfer edge, before the walk starts
    rdtc_ring #(.DEPTH(HISTORY_DEPTH)) u_ring (
        .clk     (clk),
        .we      (in_xfer),
        .waddr   (wp_reg),
        .wsample (sample_ch.readiness_sample),
        .wstamp  (clock_next),
        .re      (rd_en),
        .raddr   (rd_addr),
        .rsample (rd_sample),
        .rstamp  (rd_stamp)
    );

    // walk starts at the slot just written, covering every held entry
    rdtc_walk #(.DEPTH(HISTORY_DEPTH)) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_xfer),
        .start_slot  (wp_reg),
        .start_count (held_next),
        .clock_now   (clock_reg),
        .short_win   (short_window_reg),
        .long_win    (long_window_reg),
        .take        (take),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_sample   (rd_sample),
        .rd_stamp    (rd_stamp),
        .status      (walk_st)
    );

    // classify once the walk is done and the output register is free
    assign take       = walk_st.done && (!out_valid_reg || level_ch.ready);
    assign fall_short = $signed({1'b0, walk_st.ref_short}) - $signed({1'b0, r_now_reg});
    assign fall_long  = $signed({1'b0, walk_st.ref_long}) - $signed({1'b0, r_now_reg});

    always_comb
    begin
        priority if (r_now_reg < high_floor_reg
                     || fall_short >= $signed({1'b0, high_drop_reg}))
        begin
            level_next = LEVEL_HIGH;
        end
        else if (r_now_reg < elevated_floor_reg
                 || fall_short >= $signed({1'b0, elevated_drop_reg}))
        begin
            level_next = LEVEL_ELEVATED;
        end
        else if (fall_long >= $signed({1'b0, watch_drop_reg}))
        begin
            level_next = LEVEL_WATCH;
        end
        else
        begin
            level_next = LEVEL_NONE;
        end
    end

    assign out_valid_next = take ? 1'b1 : (level_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg     <= '0;
            wp_reg        <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clock_reg     <= clock_next;
            wp_reg        <= wp_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            r_now_reg <= sample_ch.readiness_sample;
        end
        if (take)
        begin
            level_reg <= level_next;
        end
    end

    // register file; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_window_reg   <= RST_SHORT_WINDOW;
            long_window_reg    <= RST_LONG_WINDOW;
            high_floor_reg     <= RST_HIGH_FLOOR;
            high_drop_reg      <= RST_HIGH_DROP;
            elevated_floor_reg <= RST_ELEVATED_FLOOR;
            elevated_drop_reg  <= RST_ELEVATED_DROP;
            watch_drop_reg     <= RST_WATCH_DROP;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_ch.reg_index)
                REG_SHORT_WINDOW:   short_window_reg   <= cfg_ch.wr_data;
                REG_LONG_WINDOW:    long_window_reg    <= cfg_ch.wr_data;
                REG_HIGH_FLOOR:     high_floor_reg     <= cfg_ch.wr_data;
                REG_HIGH_DROP:      high_drop_reg      <= cfg_ch.wr_data;
                REG_ELEVATED_FLOOR: elevated_floor_reg <= cfg_ch.wr_data;
                REG_ELEVATED_DROP:  elevated_drop_reg  <= cfg_ch.wr_data;
                REG_WATCH_DROP:     watch_drop_reg     <= cfg_ch.wr_data;
                default:            ;
            endcase
        end
    end

    assign level_ch.valid       = out_valid_reg;
    assign level_ch.trend_level = level_reg;

endmodule

// ===== hdl/rdtc_checker.sv =====
// ----------------------------------------------------------------------------
// rdtc_checker
// Port-level checks on the classifier core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdtc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rdtc_pkg::LEVEL_W-1:0] out_level
);

    // a stalled result stays offered, unchanged
    `RDTC_ASSERT(a_out_hold_valid, (out_valid && !out_ready) |=> out_valid)
    `RDTC_ASSERT_HOLD(a_out_hold_level, out_valid && !out_ready, out_level)

    // after an accepted sample, the block stays busy while the walk is under way
    `RDTC_ASSERT(a_busy_after_xfer, (in_valid && in_ready) |=> !in_ready ##1 !in_ready)

    // a new result only appears from a walk in progress
    `RDTC_ASSERT(a_result_from_walk, $rose(out_valid) |-> !$past(in_ready))

endmodule

bind readiness_drop_trend_classifier_core rdtc_checker u_rdtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (level_ch.valid),
    .out_ready (level_ch.ready),
    .out_level (level_ch.trend_level)
);
